>>> rtl/mbp_pkg.sv
package mbp_pkg;

	// Widths fixed by the register map and the result format.
	localparam int BB_W   = 13;  // block size register, also fill and byte counts
	localparam int BC_W   = 11;  // block count register
	localparam int MP_W   = 9;   // minimum part register
	localparam int LEN_W  = 13;  // message length
	localparam int SEQ_W  = 32;
	localparam int HDR_BYTES = 16;
	localparam int MIN_PART_MAX = 480;
	localparam int MIN_BLOCK_BYTES = 512;
	localparam int MIN_BLOCKS = 2;

	// Results per request that are delivered; any beyond are dropped.
	localparam int MAX_RES = 20;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	typedef enum logic [1:0] {
		REG_BLOCK_BYTES = 2'd0,
		REG_BLOCK_COUNT = 2'd1,
		REG_MIN_PART    = 2'd2,
		REG_NONE        = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		KIND_PART   = 2'd0,
		KIND_SEAL   = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		OP_PLACE = 1'b0,
		OP_SEAL  = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SPACE,
		ST_MIN,
		ST_FIT,
		ST_SEAL,
		ST_PSZ,
		ST_PART,
		ST_REJ
	} state_t;

	// Effective (clamped) configuration handed to the sequencer.
	typedef struct packed {
		logic [BB_W-1:0] cap;    // usable bytes after the block header
		logic [BC_W-1:0] count;  // blocks in the ring
		logic [MP_W-1:0] minp;   // least data bytes of a part
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [9:0]  block_index;
		logic [11:0] data_offset;
		logic [31:0] msg_seq;
		logic [3:0]  part_index;
		logic [11:0] part_bytes;
		logic [12:0] total_bytes;
		logic [31:0] block_seq;
		logic [11:0] used_bytes;
		logic        last;
	} res_t;

endpackage

>>> rtl/message_block_packer.sv
// Message block packer: lays messages out as parts in a ring of flash blocks.
// Input stream: one beat per request. s_tuser selects placing a message of
// s_tdata bytes or sealing the current block. Output stream: one beat per
// placed part, per sealed block, or per rejected empty or oversize message;
// m_tuser gives the kind and m_tlast marks the final beat of a request.
// Configuration goes through the APB port (block size, block count and
// minimum part size) and must be written only while the packer is idle
// (not enforced). Each request runs through a small sequencer around a
// single subtractor, one compare per cycle, from dispatch: a message on
// to space, minimum, fit, size and part per part, after a seal if it does
// not fit, a seal to seal if the block is not empty, a rejection to
// reject. The input is not ready until the request is done, but the next
// request is accepted while the last result waits in the output register.
// Reset clears the fill, the write block and both sequence numbers and
// restores the register defaults. When the receiver stalls, the sequencer
// holds at its next result until the output register frees up.
module message_block_packer import mbp_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int MAX_BLOCKS      = 1024,
	parameter int MAX_MSG_BYTES   = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // msg_len[12:0]
	input  logic [0:0]        s_tuser,   // op[0]
	output logic              m_tvalid,
	input  logic              m_tready,
	// block_index[9:0], data_offset[21:10], msg_seq[53:22], part_index[57:54],
	// part_bytes[69:58], total_bytes[82:70], block_seq[114:83],
	// used_bytes[126:115]
	output logic [127:0]      m_tdata,
	output logic [1:0]        m_tuser,   // kind[1:0]
	output logic              m_tlast
);

	cfg_t cfg;
	res_t res;

	mbp_regs #(
		.MAX_BLOCK_BYTES (MAX_BLOCK_BYTES),
		.MAX_BLOCKS      (MAX_BLOCKS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	mbp_seq #(
		.MAX_BLOCKS    (MAX_BLOCKS),
		.MAX_MSG_BYTES (MAX_MSG_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (op_t'(s_tuser[0])),
		.in_len    (s_tdata[LEN_W-1:0]),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	assign m_tdata = {1'b0, res.used_bytes, res.block_seq, res.total_bytes,
		res.part_bytes, res.part_index, res.msg_seq, res.data_offset,
		res.block_index};
	assign m_tuser = res.kind;
	assign m_tlast = res.last;

endmodule

>>> rtl/mbp_alu.sv
module mbp_alu import mbp_pkg::*; (
	input  logic [BB_W-1:0] a,
	input  logic [BB_W-1:0] b,
	output logic [BB_W-1:0] diff,
	output logic            borrow
);

	// Single subtractor; borrow set means a < b.
	assign {borrow, diff} = {1'b0, a} - {1'b0, b};

endmodule

>>> rtl/mbp_regs.sv
module mbp_regs import mbp_pkg::*; #(
	parameter int MAX_BLOCK_BYTES = 4096,
	parameter int MAX_BLOCKS      = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [BB_W-1:0] block_bytes_q;
	logic [BC_W-1:0] block_count_q;
	logic [MP_W-1:0] min_part_q;
	cfg_t            cfg_q;
	reg_idx_t        idx;
	logic            wr_en;

	function automatic logic [BB_W-1:0] cap_of(input logic [BB_W-1:0] v);
		logic [BB_W-1:0] e;
		if (v < BB_W'(MIN_BLOCK_BYTES)) begin
			e = BB_W'(MIN_BLOCK_BYTES);
		end else if (32'(v) > 32'(MAX_BLOCK_BYTES)) begin
			e = BB_W'(MAX_BLOCK_BYTES);
		end else begin
			e = v;
		end
		return e - BB_W'(HDR_BYTES);
	endfunction

	function automatic logic [BC_W-1:0] count_of(input logic [BC_W-1:0] v);
		logic [BC_W-1:0] e;
		if (v < BC_W'(MIN_BLOCKS)) begin
			e = BC_W'(MIN_BLOCKS);
		end else if (32'(v) > 32'(MAX_BLOCKS)) begin
			e = BC_W'(MAX_BLOCKS);
		end else begin
			e = v;
		end
		return e;
	endfunction

	function automatic logic [MP_W-1:0] minp_of(input logic [MP_W-1:0] v);
		logic [MP_W-1:0] e;
		if (v == '0) begin
			e = MP_W'(1);
		end else if (v > MP_W'(MIN_PART_MAX)) begin
			e = MP_W'(MIN_PART_MAX);
		end else begin
			e = v;
		end
		return e;
	endfunction

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_bytes_q <= BB_W'(4096);
			block_count_q <= BC_W'(1024);
			min_part_q    <= MP_W'(16);
		end else if (wr_en) begin
			case (idx)
				REG_BLOCK_BYTES: block_bytes_q <= pwdata[BB_W-1:0];
				REG_BLOCK_COUNT: block_count_q <= pwdata[BC_W-1:0];
				REG_MIN_PART:    min_part_q    <= pwdata[MP_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamped copies are registered and follow the raw registers in the next cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cap   <= cap_of(BB_W'(4096));
			cfg_q.count <= count_of(BC_W'(1024));
			cfg_q.minp  <= minp_of(MP_W'(16));
		end else begin
			cfg_q.cap   <= cap_of(block_bytes_q);
			cfg_q.count <= count_of(block_count_q);
			cfg_q.minp  <= minp_of(min_part_q);
		end
	end

	assign cfg = cfg_q;

	always_comb begin
		case (idx)
			REG_BLOCK_BYTES: prdata = APB_DW'(block_bytes_q);
			REG_BLOCK_COUNT: prdata = APB_DW'(block_count_q);
			REG_MIN_PART:    prdata = APB_DW'(min_part_q);
			default:         prdata = '0;
		endcase
	end

endmodule

>>> rtl/mbp_seq.sv
module mbp_seq import mbp_pkg::*; #(
	parameter int MAX_BLOCKS    = 1024,
	parameter int MAX_MSG_BYTES = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	output logic             in_ready,
	input  op_t              in_op,
	input  logic [LEN_W-1:0] in_len,
	output logic             out_valid,
	input  logic             out_ready,
	output res_t             out_res
);

	localparam int BLK_W = (MAX_BLOCKS > 2) ? $clog2(MAX_BLOCKS) : 1;

	state_t             state_q, state_d;
	op_t                op_q;
	logic [LEN_W-1:0]   len_q;
	logic [BB_W-1:0]    rem_q, remn_q, space_q, mn_q, part_q, fill_q;
	logic               lastp_q;
	logic [3:0]         pidx_q;
	logic [SEQ_W-1:0]   mseq_q, mseql_q, bseq_q;
	logic [BLK_W-1:0]   wb_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	res_t               res_q;

	logic [BB_W-1:0]    alu_a, alu_b, alu_diff;
	logic               alu_borrow;
	logic [BB_W-1:0]    part_max;
	logic [BLK_W:0]     wb_inc;
	logic [BLK_W-1:0]   wb_next;
	logic [SEQ_W-1:0]   bseq_next;
	logic               suppress, can_emit, go, emit, fill_nz, bad_len, cap_hit;
	res_t               res_d;

	mbp_alu u_alu (
		.a      (alu_a),
		.b      (alu_b),
		.diff   (alu_diff),
		.borrow (alu_borrow)
	);

	assign suppress  = (cnt_q == CNT_W'(MAX_RES));
	assign cap_hit   = (cnt_q == CNT_W'(MAX_RES - 1));
	assign can_emit  = !out_valid_q || out_ready;
	assign go        = can_emit || suppress;
	assign fill_nz   = (fill_q != '0);
	assign bad_len   = (len_q == '0) || (32'(len_q) > 32'(MAX_MSG_BYTES));
	assign part_max  = space_q - BB_W'(HDR_BYTES);
	assign bseq_next = bseq_q + SEQ_W'(1);
	assign wb_inc    = (BLK_W+1)'(wb_q) + (BLK_W+1)'(1);
	// Wraps also when the index already lies beyond a reduced block count.
	assign wb_next   = (32'(wb_inc) >= 32'(cfg.count)) ? '0 : wb_inc[BLK_W-1:0];

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DISPATCH;
			end
			ST_DISPATCH: begin
				if (op_q == OP_SEAL) begin
					state_d = fill_nz ? ST_SEAL : ST_IDLE;
				end else if (bad_len) begin
					state_d = ST_REJ;
				end else begin
					state_d = ST_SPACE;
				end
			end
			ST_SPACE: state_d = ST_MIN;
			ST_MIN:   state_d = ST_FIT;
			ST_FIT: begin
				state_d = alu_borrow ? ST_SEAL : ST_PSZ;
			end
			ST_SEAL: begin
				if (go || !fill_nz) state_d = (op_q == OP_SEAL) ? ST_IDLE : ST_PSZ;
			end
			ST_PSZ: state_d = ST_PART;
			ST_PART: begin
				if (go) state_d = lastp_q ? ST_IDLE : ST_SPACE;
			end
			ST_REJ: begin
				if (go) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Shared unit operands, handshake and result contents.
	always_comb begin
		alu_a    = '0;
		alu_b    = '0;
		emit     = 1'b0;
		res_d    = '0;
		in_ready = (state_q == ST_IDLE);
		case (state_q)
			ST_SPACE: begin
				alu_a = cfg.cap;
				alu_b = fill_q;
			end
			ST_MIN: begin
				alu_a = rem_q;
				alu_b = BB_W'(cfg.minp);
			end
			ST_FIT: begin
				// A borrow means the part header and its least data do not fit.
				alu_a = space_q;
				alu_b = mn_q + BB_W'(HDR_BYTES);
			end
			ST_PSZ: begin
				alu_a = rem_q;
				alu_b = part_max;
			end
			ST_SEAL: begin
				emit              = go && fill_nz;
				res_d.kind        = KIND_SEAL;
				res_d.block_index = 10'(wb_q);
				res_d.block_seq   = bseq_next;
				res_d.used_bytes  = 12'(fill_q);
				res_d.last        = (op_q == OP_SEAL) || cap_hit;
			end
			ST_PART: begin
				emit              = go;
				res_d.kind        = KIND_PART;
				res_d.block_index = 10'(wb_q);
				res_d.data_offset = 12'(fill_q);
				res_d.msg_seq     = mseq_q;
				res_d.part_index  = pidx_q;
				res_d.part_bytes  = 12'(part_q);
				res_d.total_bytes = len_q;
				res_d.last        = lastp_q || cap_hit;
			end
			ST_REJ: begin
				emit       = go;
				res_d.kind = KIND_REJECT;
				res_d.last = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_PLACE;
			fill_q      <= '0;
			wb_q        <= '0;
			bseq_q      <= '0;
			mseql_q     <= '0;
			cnt_q       <= '0;
			pidx_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit && !suppress) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (emit && !suppress) cnt_q <= cnt_q + CNT_W'(1);
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q  <= in_op;
						cnt_q <= '0;
					end
				end
				// The part counter restarts with every accepted request.
				ST_DISPATCH: pidx_q <= '0;
				ST_SEAL: begin
					if (emit) begin
						bseq_q <= bseq_next;
						wb_q   <= wb_next;
						fill_q <= '0;
					end
				end
				ST_PART: begin
					if (emit) begin
						fill_q <= fill_q + BB_W'(HDR_BYTES) + part_q;
						pidx_q <= pidx_q + 4'd1;
						if (lastp_q) mseql_q <= mseq_q;
					end
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the sequencer.
	always_ff @(posedge clk) begin
		if (emit && !suppress) res_q <= res_d;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) len_q <= in_len;
			end
			ST_DISPATCH: begin
				rem_q  <= BB_W'(len_q);
				mseq_q <= mseql_q + SEQ_W'(1);
			end
			ST_SPACE: space_q <= alu_borrow ? '0 : alu_diff;
			ST_MIN:   mn_q    <= alu_borrow ? rem_q : BB_W'(cfg.minp);
			ST_SEAL:  space_q <= cfg.cap;
			ST_PSZ: begin
				if (alu_borrow || alu_diff == '0) begin
					part_q  <= rem_q;
					remn_q  <= '0;
					lastp_q <= 1'b1;
				end else begin
					part_q  <= part_max;
					remn_q  <= alu_diff;
					lastp_q <= 1'b0;
				end
			end
			ST_PART: begin
				if (emit) rem_q <= remn_q;
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule
